// ===== hw/rtl/skaf_pkg.sv =====
package skaf_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_UNCERT   = 2'd3;

	localparam logic [15:0] TIME_STEP_RST     = 16'd262;
	localparam logic [31:0] PROCESS_NOISE_RST = 32'd4295;
	localparam logic [31:0] MEAS_NOISE_RST    = 32'd150994944;
	localparam logic [31:0] INIT_UNCERT_RST   = 32'd67108864;

	// gain divider: one quotient bit per step, bits 16 down to 0
	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// shared multiplier operand select
	localparam logic [1:0] MUL_PRED = 2'd0;
	localparam logic [1:0] MUL_CORR = 2'd1;
	localparam logic [1:0] MUL_VAR  = 2'd2;

	typedef struct packed {
		logic [15:0] time_step;
		logic [31:0] process_noise;
		logic [31:0] measurement_noise;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       pred_upd;
		logic       div_init;
		logic       div_step;
		logic       corr_upd;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic out_busy;
	} sts_t;

endpackage

// ===== hw/rtl/skaf_in_if.sv =====
interface skaf_in_if;
	logic               valid;
	logic               ready;
	logic               axis;
	logic signed [31:0] rate;
	logic signed [31:0] measured_angle;

	modport source (output valid, output axis, output rate, output measured_angle, input ready);
	modport sink (input valid, input axis, input rate, input measured_angle, output ready);
endinterface

// ===== hw/rtl/skaf_out_if.sv =====
interface skaf_out_if;
	logic               valid;
	logic               ready;
	logic               axis_out;
	logic signed [31:0] angle_estimate;
	logic        [31:0] estimate_uncertainty;

	modport source (output valid, output axis_out, output angle_estimate,
		output estimate_uncertainty, input ready);
	modport sink (input valid, input axis_out, input angle_estimate,
		input estimate_uncertainty, output ready);
endinterface

// ===== hw/rtl/scalar_kalman_angle_filter.sv =====
// one-dimensional kalman tilt filter with an independent channel per axis: each input
// transaction names an axis and carries a gyro rate and an accelerometer angle (signed
// q16.16); the block predicts, computes the gain u/(u+measurement_noise) with a
// restoring divider, corrects, and returns the axis, the saturated q16.16 angle and the
// q8.24 variance. one transaction is in flight at a time. the gain divider makes one
// quotient bit per cycle, and one shared multiplier serves the three products.
// a finished result sits in the output register, so a new input is taken while it waits;
// if the previous result is still unclaimed when the next one is ready, the block holds.
// configuration writes are taken at any time but are meant to happen while idle; a write
// to initial_uncertainty has no effect, as that value is only loaded by reset
module scalar_kalman_angle_filter #(
	parameter int AXES = 2
) (
	input logic                            clk,
	input logic                            arst_n,
	skaf_in_if.sink                        in_ch,
	skaf_out_if.source                     out_ch,
	input logic                            cfg_we,
	input logic [skaf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [skaf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import skaf_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// register file for the three live settings
	skaf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// sequencer: load, predict, divide, correct, commit
	skaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// per-axis state, shared multiplier, divider and output register
	skaf_datapath #(
		.AXES (AXES)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg),
		.cmd                  (cmd),
		.sts                  (sts),
		.axis                 (in_ch.axis),
		.rate                 (in_ch.rate),
		.measured_angle       (in_ch.measured_angle),
		.out_ready            (out_ch.ready),
		.out_valid            (out_ch.valid),
		.axis_out             (out_ch.axis_out),
		.angle_estimate       (out_ch.angle_estimate),
		.estimate_uncertainty (out_ch.estimate_uncertainty)
	);
endmodule

// ===== hw/rtl/skaf_cfg.sv =====
module skaf_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  logic [skaf_pkg::CFG_IDX_W-1:0]     index,
	input  logic [skaf_pkg::CFG_DATA_W-1:0]    data,
	output skaf_pkg::cfg_t                     cfg
);
	import skaf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step         <= TIME_STEP_RST;
			cfg_q.process_noise     <= PROCESS_NOISE_RST;
			cfg_q.measurement_noise <= MEAS_NOISE_RST;
		end else if (we) begin
			unique case (index)
				REG_TIME_STEP:     cfg_q.time_step         <= data[15:0];
				REG_PROCESS_NOISE: cfg_q.process_noise     <= data;
				REG_MEAS_NOISE:    cfg_q.measurement_noise <= data;
				// only loaded into the variance store by reset, which restores the default
				REG_INIT_UNCERT: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== hw/rtl/skaf_ctrl.sv =====
module skaf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  skaf_pkg::sts_t sts,
	output skaf_pkg::cmd_t cmd
);
	import skaf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PMUL  = 3'd1;
	localparam logic [2:0] ST_PUPD  = 3'd2;
	localparam logic [2:0] ST_DINIT = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_CMUL  = 3'd5;
	localparam logic [2:0] ST_CUPD  = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PMUL;
				end
			end
			ST_PMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PRED;
				state_d     = ST_PUPD;
			end
			ST_PUPD: begin
				cmd.pred_upd = 1'b1;
				state_d      = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_CMUL;
				end
			end
			ST_CMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CORR;
				state_d     = ST_CUPD;
			end
			ST_CUPD: begin
				// angle correction and the variance product share this cycle
				cmd.corr_upd = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_VAR;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free && !sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end
endmodule

// ===== hw/rtl/skaf_datapath.sv =====
module skaf_datapath #(
	parameter int AXES = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  skaf_pkg::cfg_t     cfg,
	input  skaf_pkg::cmd_t     cmd,
	output skaf_pkg::sts_t     sts,
	input  logic               axis,
	input  logic signed [31:0] rate,
	input  logic signed [31:0] measured_angle,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               axis_out,
	output logic signed [31:0] angle_estimate,
	output logic        [31:0] estimate_uncertainty
);
	import skaf_pkg::*;

	localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

	function automatic logic signed [31:0] sat32(input logic signed [36:0] x);
		if (x > 37'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (x < -37'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return x[31:0];
		end
	endfunction

	logic signed [31:0] angle_store_q [AXES];
	logic        [31:0] var_store_q   [AXES];

	logic               axis_q, axis_ok_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [31:0] rate_q, meas_q, angle_q;
	logic        [31:0] u_q;
	logic        [32:0] den_q;
	logic        [33:0] rem_q;
	logic        [16:0] quo_q;
	logic               den_zero_q;
	logic signed [51:0] prod_q;
	logic               out_valid_q;

	logic               axis_ok;
	logic [IDX_W-1:0]   idx;
	logic signed [32:0] diff;
	logic        [15:0] gain;
	logic        [16:0] inv_gain;
	logic signed [17:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [51:0] rnd_full;
	logic signed [36:0] ang_sum;
	logic        [32:0] u_sum;
	logic               ge;
	logic        [33:0] rem_sub;

	assign axis_ok = (AXES > 1) || !axis;
	assign idx     = axis_ok ? IDX_W'(axis) : '0;

	assign diff     = {meas_q[31], meas_q} - {angle_q[31], angle_q};
	assign gain     = den_zero_q ? 16'd0 : (quo_q[16] ? 16'hFFFF : quo_q[15:0]);
	assign inv_gain = 17'h10000 - {1'b0, gain};

	always_comb begin
		case (cmd.mul_sel)
			MUL_PRED: begin
				mul_a = {2'b00, cfg.time_step};
				mul_b = {{2{rate_q[31]}}, rate_q};
			end
			MUL_CORR: begin
				mul_a = {2'b00, gain};
				mul_b = {diff[32], diff};
			end
			MUL_VAR: begin
				mul_a = {1'b0, inv_gain};
				mul_b = {2'b00, u_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round to nearest, ties up, then drop the 16 fraction bits
	assign rnd_full = (prod_q + 52'sd32768) >>> 16;
	assign ang_sum  = {{5{angle_q[31]}}, angle_q} + rnd_full[36:0];
	assign u_sum    = {1'b0, u_q} + {1'b0, cfg.process_noise};

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			axis_q    <= axis;
			axis_ok_q <= axis_ok;
			idx_q     <= idx;
			rate_q    <= rate;
			meas_q    <= measured_angle;
			angle_q   <= angle_store_q[idx];
			u_q       <= var_store_q[idx];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.pred_upd) begin
			angle_q <= sat32(ang_sum);
			u_q     <= u_sum[32] ? 32'hFFFFFFFF : u_sum[31:0];
		end
		if (cmd.div_init) begin
			den_q      <= {1'b0, u_q} + {1'b0, cfg.measurement_noise};
			rem_q      <= {2'b00, u_q};
			quo_q      <= '0;
			den_zero_q <= (u_q == '0) && (cfg.measurement_noise == '0);
		end
		if (cmd.div_step) begin
			rem_q <= {rem_sub[32:0], 1'b0};
			quo_q <= {quo_q[15:0], ge};
		end
		if (cmd.corr_upd) begin
			angle_q <= sat32(ang_sum);
		end
		if (cmd.commit) begin
			axis_out             <= axis_q;
			angle_estimate       <= axis_ok_q ? angle_q : 32'sd0;
			estimate_uncertainty <= axis_ok_q ? rnd_full[31:0] : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				angle_store_q[i] <= '0;
				var_store_q[i]   <= INIT_UNCERT_RST;
			end
		end else if (cmd.commit && axis_ok_q) begin
			angle_store_q[idx_q] <= angle_q;
			var_store_q[idx_q]   <= rnd_full[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.out_busy = 1'b0;
endmodule

// ===== hw/rtl/skaf_checker.sv =====
module skaf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               axis_out,
	input logic signed [31:0] angle_estimate,
	input logic        [31:0] estimate_uncertainty
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(axis_out)
			&& $stable(angle_estimate) && $stable(estimate_uncertainty))
		else $error("stalled result changed");

	// one transaction in flight: no input taken right after one was accepted
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after acceptance");

	// a result only appears out of a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

	// a result never shows up in the cycle after an input is accepted
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");

endmodule

bind scalar_kalman_angle_filter skaf_checker u_skaf_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.in_valid             (in_ch.valid),
	.in_ready             (in_ch.ready),
	.out_valid            (out_ch.valid),
	.out_ready            (out_ch.ready),
	.axis_out             (out_ch.axis_out),
	.angle_estimate       (out_ch.angle_estimate),
	.estimate_uncertainty (out_ch.estimate_uncertainty)
);

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import skaf_pkg::*;

	localparam int AXES = 2;

	// q16.16 limits, used both for saturation and as stimulus extremes
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef enum logic {
		ROW_WRITE,
		ROW_ITEM
	} row_kind_t;

	// one line of the directed table: either a register write or an input transaction,
	// optionally with the result typed in by hand
	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          wdata;
		logic                 axis;
		logic [31:0]          rate;
		logic [31:0]          meas;
		bit                   typed;
		logic [31:0]          exp_angle;
		logic [31:0]          exp_var;
	} stim_row_t;

	typedef struct {
		logic        axis;
		logic [31:0] angle;
		logic [31:0] variance;
	} filt_out_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	skaf_in_if  in_ch ();
	skaf_out_if out_ch ();

	scalar_kalman_angle_filter #(
		.AXES(AXES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// filter state as the testbench believes it to be
	logic signed [31:0] angle_est [AXES];
	logic        [31:0] var_est   [AXES];

	// shadow of the configuration registers
	logic [15:0] ts_reg;
	logic [31:0] pn_reg;
	logic [31:0] mn_reg;
	logic [31:0] init_reg;  // only ever loaded into the variances at reset

	// results still owed by the block, oldest first
	filt_out_t estimates_due [$];

	int in_gap_pct;
	int out_stall_pct;
	int mismatches;
	int results_seen;
	int items_sent;
	int settings_used;

	// directed part: extremes of every field on both axes under the reset settings, then
	// the prediction pushed into saturation, the variance sum saturated, the variance run
	// down to zero and finally the zero-denominator gain, where the angle only integrates
	stim_row_t directed_rows [$] = '{
		'{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, Q_MAX,         Q_MAX,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, Q_MIN,         Q_MIN,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, ALL_ONES,      32'h0000_0001, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0001, ALL_ONES,      1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, '0, '0},
		// upper half of the data is dropped by the 16 bit register
		'{ROW_WRITE, REG_TIME_STEP,   ALL_ONES, 1'b0, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_INIT_UNCERT, ALL_ONES, 1'b0, '0, '0, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, Q_MAX,         Q_MAX,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, Q_MAX,         Q_MAX,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, Q_MIN,         Q_MIN,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, Q_MIN,         Q_MIN,         1'b0, '0, '0},
		'{ROW_WRITE, REG_PROCESS_NOISE, ALL_ONES, 1'b0, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_MEAS_NOISE,    ALL_ONES, 1'b0, '0, '0, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, 32'h0001_0000, 32'h0002_0000, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, 32'hFFFF_0000, Q_MAX,         1'b0, '0, '0},
		// no noise at all: gain pins at its maximum and the variance falls to zero
		'{ROW_WRITE, REG_PROCESS_NOISE, 32'h0, 1'b0, '0, '0, 1'b0, '0, '0},
		'{ROW_WRITE, REG_MEAS_NOISE,    32'h0, 1'b0, '0, '0, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0000, 32'h0000_8000, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0000, 32'hFFFF_8000, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0000, Q_MAX,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, 32'h0000_0000, Q_MIN,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, 32'h0000_0000, 32'h1234_5678, 1'b0, '0, '0},
		// zero variance and zero noise: gain is zero, three full-scale steps must saturate
		'{ROW_ITEM,  '0, '0, 1'b0, Q_MAX,         Q_MIN,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, Q_MAX,         Q_MIN,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b0, Q_MAX,         Q_MIN,         1'b1, Q_MAX, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, Q_MIN,         Q_MAX,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, Q_MIN,         Q_MAX,         1'b0, '0, '0},
		'{ROW_ITEM,  '0, '0, 1'b1, Q_MIN,         Q_MAX,         1'b1, Q_MIN, '0},
		// nothing to integrate and no gain: the saturated angle just holds
		'{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, Q_MAX, '0}
	};

	function automatic longint sat_s32(input longint x);
		if (x > S32_MAX)
			return S32_MAX;
		if (x < S32_MIN)
			return S32_MIN;
		return x;
	endfunction

	// drop 16 fraction bits, rounding to nearest with ties towards plus infinity
	function automatic longint round_q16(input longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	// one predict and correct pass of the chosen channel; updates the shadow state
	function automatic filt_out_t kalman_update(input logic ax, input logic signed [31:0] rate,
		input logic signed [31:0] meas);
		longint angle;
		longint diff;
		longint unsigned u;
		longint unsigned den;
		longint unsigned gain;
		filt_out_t res;

		// predict: integrate the gyro rate, grow the variance
		angle = sat_s32(longint'(angle_est[ax]) + round_q16(longint'(ts_reg) * longint'(rate)));
		u = var_est[ax];
		u += pn_reg;
		if (u > 64'hFFFF_FFFF)
			u = 64'hFFFF_FFFF;

		// q0.16 gain, zero when both variance and measurement noise are zero
		den = u + mn_reg;
		gain = (den == 0) ? 64'd0 : (u << 16) / den;
		if (gain > 64'hFFFF)
			gain = 64'hFFFF;

		// correct towards the accelerometer angle and shrink the variance
		diff = longint'(meas) - angle;
		angle = sat_s32(angle + round_q16(longint'(gain) * diff));
		u = ((64'd65536 - gain) * u + 64'd32768) >> 16;

		angle_est[ax] = angle[31:0];
		var_est[ax] = u[31:0];
		res.axis = ax;
		res.angle = angle[31:0];
		res.variance = u[31:0];
		return res;
	endfunction

	function automatic logic [31:0] boundary_word();
		case ($urandom_range(4))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 32'h0000_0000;
			3: return ALL_ONES;
			default: return 32'h0000_0001;
		endcase
	endfunction

	// one register write, taken at the next rising edge; the caller's next transaction
	// lowers the write enable
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_TIME_STEP:     ts_reg = value[15:0];
			REG_PROCESS_NOISE: pn_reg = value;
			REG_MEAS_NOISE:    mn_reg = value;
			REG_INIT_UNCERT:   init_reg = value;
			default: ;
		endcase
	endtask

	// stop offering input and let every owed result come back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (estimates_due.size() != 0)
			@(posedge clk);
	endtask

	// offer one input transaction, with a random gap in front when the sender idles;
	// the expectation is worked out at the edge where the block takes it
	task automatic send_item(input logic ax, input logic [31:0] r, input logic [31:0] m,
		input bit typed, input logic [31:0] exp_angle, input logic [31:0] exp_var);
		filt_out_t due;

		if (cfg_we)
			cfg_we <= 1'b0;
		while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.axis <= ax;
		in_ch.rate <= r;
		in_ch.measured_angle <= m;
		do
			@(posedge clk);
		while (!in_ch.ready);
		due = kalman_update(ax, r, m);
		if (typed) begin
			due.angle = exp_angle;
			due.variance = exp_var;
		end
		estimates_due.push_back(due);
		items_sent++;
	endtask

	// mostly plausible sensor streams (rates within a few hundred deg/s, angles near the
	// current estimate), with full-range words and extremes mixed in
	task automatic send_random();
		logic ax;
		logic [31:0] r;
		logic [31:0] m;
		longint near;
		int pick;

		ax = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 70)
			r = $urandom_range(65536000) - 32'd32768000;
		else if (pick < 90)
			r = $urandom;
		else
			r = boundary_word();

		pick = $urandom_range(99);
		if (pick < 60) begin
			near = longint'(angle_est[ax]) + longint'($urandom_range(11796480)) - 64'sd5898240;
			near = sat_s32(near);
			m = near[31:0];
		end else if (pick < 85) begin
			m = $urandom;
		end else begin
			m = boundary_word();
		end
		send_item(ax, r, m, 1'b0, '0, '0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a correct run needs well under a tenth of this
	initial begin
		#5ms;
		$display("timeout with %0d results still owed", estimates_due.size());
		$display("CHECK FAILED");
		$finish;
	end

	// result side: claim transactions with random stalls and compare each against the
	// oldest owed estimate
	initial begin
		filt_out_t want;

		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (estimates_due.size() == 0) begin
					mismatches++;
					$display("%t unexpected result: expected none, got axis %0d angle %h variance %h",
						$time, out_ch.axis_out, out_ch.angle_estimate,
						out_ch.estimate_uncertainty);
				end else begin
					want = estimates_due.pop_front();
					if (out_ch.axis_out !== want.axis) begin
						mismatches++;
						$display("%t axis_out expected %0d got %0d", $time, want.axis,
							out_ch.axis_out);
					end
					if (out_ch.angle_estimate !== want.angle) begin
						mismatches++;
						$display("%t axis %0d angle_estimate expected %h got %h", $time,
							want.axis, want.angle, out_ch.angle_estimate);
					end
					if (out_ch.estimate_uncertainty !== want.variance) begin
						mismatches++;
						$display("%t axis %0d estimate_uncertainty expected %h got %h",
							$time, want.axis, want.variance, out_ch.estimate_uncertainty);
					end
				end
			end
			out_ch.ready <= !(out_stall_pct != 0 && $urandom_range(99) < out_stall_pct);
		end
	end

	initial begin
		logic [15:0] ts_next;
		logic [31:0] pn_next;
		logic [31:0] mn_next;

		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		settings_used = 1;
		in_gap_pct = 0;
		out_stall_pct = 0;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.axis <= 1'b0;
		in_ch.rate <= '0;
		in_ch.measured_angle <= '0;

		// registers and both channels as they come out of reset
		ts_reg = TIME_STEP_RST;
		pn_reg = PROCESS_NOISE_RST;
		mn_reg = MEAS_NOISE_RST;
		init_reg = INIT_UNCERT_RST;
		for (int i = 0; i < AXES; i++) begin
			angle_est[i] = '0;
			var_est[i] = init_reg;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed_rows[i].index, directed_rows[i].wdata);
			end else begin
				send_item(directed_rows[i].axis, directed_rows[i].rate, directed_rows[i].meas,
					directed_rows[i].typed, directed_rows[i].exp_angle, directed_rows[i].exp_var);
			end
		end
		settings_used += 3;

		// random phases: each one gets its own register setting and idling pattern, cycling
		// through no idling, idle sender, stalling receiver and both
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
				1: begin in_gap_pct = 53; out_stall_pct = 0;  end
				2: begin in_gap_pct = 0;  out_stall_pct = 53; end
				default: begin in_gap_pct = 32; out_stall_pct = 32; end
			endcase
			case (phase)
				0: begin ts_next = TIME_STEP_RST; pn_next = PROCESS_NOISE_RST;
					mn_next = MEAS_NOISE_RST; end
				1: begin ts_next = 16'hFFFF; pn_next = '0; mn_next = ALL_ONES; end
				2: begin ts_next = '0; pn_next = ALL_ONES; mn_next = '0; end
				3: begin ts_next = 16'($urandom); pn_next = $urandom_range(65535);
					mn_next = $urandom; end
				4: begin ts_next = 16'($urandom_range(1000)); pn_next = $urandom_range(1 << 20);
					mn_next = $urandom; end
				5: begin ts_next = 16'hFFFF; pn_next = ALL_ONES; mn_next = ALL_ONES; end
				6: begin ts_next = 16'($urandom); pn_next = $urandom; mn_next = $urandom; end
				default: begin ts_next = 16'd1; pn_next = 32'd1; mn_next = 32'd1; end
			endcase
			wait_idle();
			// junk in the upper half of the time step write must be ignored
			write_reg(REG_TIME_STEP, {16'($urandom), ts_next});
			write_reg(REG_PROCESS_NOISE, pn_next);
			write_reg(REG_MEAS_NOISE, mn_next);
			write_reg(REG_INIT_UNCERT, $urandom);
			settings_used++;
			repeat (125) send_random();
		end

		// drain, then give the block time to show any stray result
		wait_idle();
		repeat (50) @(posedge clk);

		$display("%0d input transactions (%0d directed) over %0d register settings,",
			items_sent, items_sent - 1000, settings_used);
		$display("%0d results compared, idling on neither, either and both sides",
			results_seen);
		if (mismatches == 0 && estimates_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				estimates_due.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
